### hdl/spq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the shift-register priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DEPTH_DEF = 8;
    localparam int PRI_W     = 8;
    localparam int VAL_W     = 32;
    localparam int OCC_W     = 4;

    typedef enum logic [0:0] {
        ACT_INSERT = 1'b0,
        ACT_REMOVE = 1'b1
    } t_spq_action;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_spq_status;

    // input word
    typedef struct packed {
        t_spq_action        action;
        logic [PRI_W-1:0]   entry_priority;
        logic signed [VAL_W-1:0] entry_value;
    } t_spq_in;

    // result word
    typedef struct packed {
        t_spq_status        status;
        logic signed [VAL_W-1:0] removed_value;
        logic [OCC_W-1:0]   occupancy;
    } t_spq_out;

    // contents of one slot
    typedef struct packed {
        logic [PRI_W-1:0]   pri;
        logic [VAL_W-1:0]   val;
    } t_spq_slot;

    // broadcast control from the top level to every cell
    typedef struct packed {
        logic               ins;   // insert, queue not full
        logic               rem;   // remove, queue not empty
        t_spq_slot          entry; // entry being inserted
    } t_spq_ctl;

endpackage

### hdl/sorted_priority_queue_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_core
// Bounded priority queue kept sorted in a chain of shifting slot cells.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a word on i_cmd is taken at a rising edge with start high
//   and busy low. busy is always low, so a command may be issued every cycle.
//   action = insert places the entry behind all held entries of lower or
//   equal priority; action = remove pops the head (lowest priority number).
//   Result channel: one result word per command on o_result, valid for a
//   single cycle while o_done is high, in the cycle after the command is taken.
//   The receiver cannot stall; a result not captured in that cycle is gone.
//   Throughput 1 command per cycle: every cell compares its
//   priority to the new one in parallel and loads from itself, its neighbor
//   or the command in the same cycle, so the count register is the only
//   state shared across the chain.
//   Status: done, full (insert refused, queue unchanged), or empty (remove
//   refused). removed_value is zero except on a successful remove;
//   occupancy is the entry count after the command, low 4 bits.
//   Reset (synchronous, active low) empties the queue and clears o_done.
//   Slot contents are not cleared; only slots below the count are read.
// ----------------------------------------------------------------------------
module sorted_priority_queue_core
    import spq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_spq_in   i_cmd,
    output logic      o_done,
    output t_spq_out  o_result
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_done;
    t_spq_out         r_result;
    t_spq_out         n_result;

    logic             accept;
    logic             full;
    logic             empty;
    t_spq_ctl         ctl;

    t_spq_slot        slot   [DEPTH];
    logic             gt     [DEPTH];
    logic             occ    [DEPTH];

    // busy is tied low, so no command is ever held off
    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = (r_count == CNT_W'(DEPTH));
    assign empty  = (r_count == '0);

    // broadcast control; refused commands leave the chain untouched
    always_comb begin
        ctl.ins         = accept && (i_cmd.action == ACT_INSERT) && !full;
        ctl.rem         = accept && (i_cmd.action == ACT_REMOVE) && !empty;
        ctl.entry.pri   = i_cmd.entry_priority;
        ctl.entry.val   = i_cmd.entry_value;
    end

    // chain of cells: slot 0 is the head
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_spq_slot left_slot;
        t_spq_slot right_slot;
        logic      left_gt;

        assign occ[g] = (CNT_W'(g) < r_count);

        if (g == 0) begin : g_head
            assign left_slot = slot[g];
            assign left_gt   = 1'b0;
        end else begin : g_mid
            assign left_slot = slot[g-1];
            assign left_gt   = gt[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign right_slot = slot[g];
        end else begin : g_body
            assign right_slot = slot[g+1];
        end

        spq_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (ctl),
            .i_occupied (occ[g]),
            .i_left_gt  (left_gt),
            .i_left     (left_slot),
            .i_right    (right_slot),
            .o_slot     (slot[g]),
            .o_gt       (gt[g])
        );
    end

    // entry count
    always_comb begin
        n_count = r_count;
        if (ctl.ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (ctl.rem) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // result word, built from the count after this command
    always_comb begin
        n_result.status        = ST_DONE;
        n_result.removed_value = '0;
        n_result.occupancy     = OCC_W'(n_count);
        unique case (i_cmd.action)
            ACT_INSERT: begin
                if (full) begin
                    n_result.status = ST_FULL;
                end
            end
            ACT_REMOVE: begin
                if (empty) begin
                    n_result.status = ST_EMPTY;
                end else begin
                    n_result.removed_value = slot[0].val;
                end
            end
            default: begin
                n_result.status = ST_DONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_done  <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= n_result;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count beyond depth");

    a_done_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_done)
        else $error("missing result strobe after command");

    a_full_refused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_cmd.action == ACT_INSERT && full) |=> $stable(r_count))
        else $error("insert into full queue changed the count");

    a_remove_drops_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.rem |=> (r_count == $past(r_count) - CNT_W'(1)))
        else $error("remove did not decrement the count");

    a_value_only_on_remove: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status != ST_DONE) |-> (o_result.removed_value == '0))
        else $error("value returned with a refusal status");

endmodule

### hdl/spq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: compares against the new entry and shifts.
// ----------------------------------------------------------------------------
module spq_cell
    import spq_pkg::*;
(
    input  logic       i_clk,
    input  t_spq_ctl   i_ctl,
    input  logic       i_occupied,
    input  logic       i_left_gt,   // left neighbor moves back on insert
    input  t_spq_slot  i_left,
    input  t_spq_slot  i_right,
    output t_spq_slot  o_slot,
    output logic       o_gt         // held entry sorts behind the new one
);

    t_spq_slot r_slot;
    t_spq_slot n_slot;

    assign o_gt   = i_occupied && (r_slot.pri > i_ctl.entry.pri);
    assign o_slot = r_slot;

    always_comb begin
        n_slot = r_slot;
        if (i_ctl.ins) begin
            if (i_left_gt) begin
                n_slot = i_left;
            end else if (o_gt || !i_occupied) begin
                // insertion point (or a free slot past it: harmless)
                n_slot = i_ctl.entry;
            end
        end else if (i_ctl.rem) begin
            n_slot = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

endmodule
